// ----- src/occupancy_grid_ray_tracer_top_macros.svh -----
// Assertion macros shared by the occupancy grid ray tracer checkers.
`ifndef OCCUPANCY_GRID_RAY_TRACER_TOP_MACROS_SVH
`define OCCUPANCY_GRID_RAY_TRACER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define OGRT_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define OGRT_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Checks the cycle right after a reset edge.
`define OGRT_ASSERT_AFTER_RESET(name, cons, msg) \
  name: assert property (@(posedge clk) rst |=> (cons)) else $error(msg);

`endif

// ----- src/ogrt_pkg.sv -----
// Shared types and constants of the occupancy grid ray tracer.
package ogrt_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_OCC_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_GRID_WIDTH    = 2'd1;
  localparam logic [1:0] REG_GRID_HEIGHT   = 2'd2;

  // Register reset values.
  localparam logic [7:0] OCC_THRESHOLD_RESET = 8'd128;
  localparam logic [8:0] GRID_SIZE_RESET     = 9'd256;

  // Cell classes.
  localparam logic [1:0] CLASS_UNKNOWN  = 2'd0;
  localparam logic [1:0] CLASS_FREE     = 2'd1;
  localparam logic [1:0] CLASS_OCCUPIED = 2'd2;

  // Request types.
  localparam logic REQ_TRACE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  // Largest count shown on the result ports.
  localparam logic [32:0] REPORT_MAX = 33'd65535;

  // Width of the signed line error term.
  localparam int ERR_W = 12;

  // Command kinds handed from the front to the back.
  typedef enum logic [1:0] {
    OP_REJECT = 2'd0,
    OP_TRACE  = 2'd1,
    OP_READ   = 2'd2
  } op_t;

  // One classified request. For a read, ax/ay hold the cell.
  typedef struct packed {
    op_t        op;
    logic [7:0] ax;
    logic [7:0] ay;
    logic [7:0] bx;
    logic [7:0] by;
    logic [7:0] dx;
    logic [7:0] dy_mag;
    logic       x_neg;
    logic       y_neg;
  } cmd_t;

  // One result item.
  typedef struct packed {
    logic [1:0]  cell_class;
    logic [15:0] hit_total;
    logic [15:0] free_total;
    logic [9:0]  cells_walked;
    logic        rejected;
  } res_t;

endpackage

// ----- src/occupancy_grid_ray_tracer_top.sv -----
// Top level of the occupancy grid ray tracer.
//
// Requests enter through a queue-style port: an item is taken on a clock edge
// with push high and full low. req_type selects a ray trace (start and end
// cell) or a read of one cell. Results leave the same way: while empty is low
// the oldest result sits on the result ports and is taken when pop is high.
// Configuration writes use cfg_valid/cfg_ready with a register index and data.
// Each request yields exactly one result, in request order.
// A trace walks the line, the walker updating one cell a cycle through
// read-modify-write on the hit and free counter RAMs. A read runs in
// steps (RAM read, product of threshold and touch count, compare); a
// rejected request is answered from the idle state.
// After reset the counter RAMs are zeroed by a clearing pass over all
// GRID_DIM*GRID_DIM cells (65536 by default); full stays high meanwhile while
// configuration writes are still taken. A two-entry request queue and a
// two-entry result queue let intake continue while the receiver stalls; the
// walker waits only when no result slot is free.
module occupancy_grid_ray_tracer_top #(
  parameter int GRID_DIM   = 256,
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        req_type,
  input  logic [7:0]  ray_start_x,
  input  logic [7:0]  ray_start_y,
  input  logic [7:0]  ray_end_x,
  input  logic [7:0]  ray_end_y,
  input  logic [7:0]  read_x,
  input  logic [7:0]  read_y,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  cell_class,
  output logic [15:0] hit_total,
  output logic [15:0] free_total,
  output logic [9:0]  cells_walked,
  output logic        rejected,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  import ogrt_pkg::*;

  localparam int CMD_W = $bits(cmd_t);
  localparam int RES_W = $bits(res_t);

  logic       clearing;
  logic [7:0] occ_threshold;
  logic       cmd_push;
  logic       cmd_full;
  logic       cmd_pop;
  logic       cmd_empty;
  cmd_t       cmd_in;
  cmd_t       cmd_head;
  logic       res_push;
  logic       res_full;
  res_t       res_in;
  res_t       res_head;

  ogrt_front #(.GRID_DIM(GRID_DIM)) u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .req_type      (req_type),
    .ray_start_x   (ray_start_x),
    .ray_start_y   (ray_start_y),
    .ray_end_x     (ray_end_x),
    .ray_end_y     (ray_end_y),
    .read_x        (read_x),
    .read_y        (read_y),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .clearing      (clearing),
    .cmd_full      (cmd_full),
    .cmd_push      (cmd_push),
    .cmd_data      (cmd_in),
    .occ_threshold (occ_threshold)
  );

  // Request queue between front and back.
  ogrt_fifo #(.WIDTH(CMD_W), .DEPTH(2)) u_cmd_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .din   (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .dout  (cmd_head),
    .empty (cmd_empty)
  );

  ogrt_back #(.GRID_DIM(GRID_DIM), .COUNT_BITS(COUNT_BITS)) u_back (
    .clk           (clk),
    .rst           (rst),
    .clearing      (clearing),
    .occ_threshold (occ_threshold),
    .cmd_empty     (cmd_empty),
    .cmd_data      (cmd_head),
    .cmd_pop       (cmd_pop),
    .res_full      (res_full),
    .res_push      (res_push),
    .res_data      (res_in)
  );

  // Result queue toward the receiver.
  ogrt_fifo #(.WIDTH(RES_W), .DEPTH(2)) u_res_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_head),
    .empty (empty)
  );

  assign cell_class   = res_head.cell_class;
  assign hit_total    = res_head.hit_total;
  assign free_total   = res_head.free_total;
  assign cells_walked = res_head.cells_walked;
  assign rejected     = res_head.rejected;

endmodule

// ----- src/ogrt_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module ogrt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/ogrt_fifo.sv -----
// Small first-in first-out queue built from registers.
module ogrt_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  // Payload storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

endmodule

// ----- src/ogrt_front.sv -----
// Front end: configuration registers, request intake and bounds classification.
module ogrt_front #(
  parameter int GRID_DIM = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  logic          req_type,
  input  logic [7:0]    ray_start_x,
  input  logic [7:0]    ray_start_y,
  input  logic [7:0]    ray_end_x,
  input  logic [7:0]    ray_end_y,
  input  logic [7:0]    read_x,
  input  logic [7:0]    read_y,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [8:0]    cfg_data,
  input  logic          clearing,
  input  logic          cmd_full,
  output logic          cmd_push,
  output ogrt_pkg::cmd_t cmd_data,
  output logic [7:0]    occ_threshold
);

  import ogrt_pkg::*;

  localparam int LW = ($clog2(GRID_DIM + 1) > 9) ? $clog2(GRID_DIM + 1) : 9;

  logic [8:0]    grid_width;
  logic [8:0]    grid_height;
  logic [LW-1:0] w_use;
  logic [LW-1:0] h_use;
  logic          trace_out;
  logic          read_out;

  assign cfg_ready = 1'b1;

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      occ_threshold <= OCC_THRESHOLD_RESET;
      grid_width    <= GRID_SIZE_RESET;
      grid_height   <= GRID_SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_OCC_THRESHOLD: occ_threshold <= cfg_data[7:0];
        REG_GRID_WIDTH:    grid_width    <= cfg_data;
        REG_GRID_HEIGHT:   grid_height   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // The grid in use never exceeds the physical grid.
  assign w_use = (LW'(grid_width) > LW'(GRID_DIM)) ? LW'(GRID_DIM) : LW'(grid_width);
  assign h_use = (LW'(grid_height) > LW'(GRID_DIM)) ? LW'(GRID_DIM) : LW'(grid_height);

  // Bounds checks for both request kinds.
  assign trace_out = (LW'(ray_start_x) >= w_use) || (LW'(ray_end_x) >= w_use) ||
                     (LW'(ray_start_y) >= h_use) || (LW'(ray_end_y) >= h_use);
  assign read_out  = (LW'(read_x) >= w_use) || (LW'(read_y) >= h_use);

  // Intake stalls while the queue is full or the grid is being cleared.
  assign full     = cmd_full || clearing;
  assign cmd_push = push && !full;

  // Classify the request and precompute the line deltas and directions.
  always_comb begin
    cmd_data.ax     = ray_start_x;
    cmd_data.ay     = ray_start_y;
    cmd_data.bx     = ray_end_x;
    cmd_data.by     = ray_end_y;
    cmd_data.dx     = (ray_end_x > ray_start_x) ? ray_end_x - ray_start_x
                                                : ray_start_x - ray_end_x;
    cmd_data.dy_mag = (ray_end_y > ray_start_y) ? ray_end_y - ray_start_y
                                                : ray_start_y - ray_end_y;
    cmd_data.x_neg  = !(ray_start_x < ray_end_x);
    cmd_data.y_neg  = !(ray_start_y < ray_end_y);
    if (req_type == REQ_READ) begin
      cmd_data.ax = read_x;
      cmd_data.ay = read_y;
      cmd_data.op = read_out ? OP_REJECT : OP_READ;
    end else begin
      cmd_data.op = trace_out ? OP_REJECT : OP_TRACE;
    end
  end

endmodule

// ----- src/ogrt_back.sv -----
// Back end: grid clearing, line walker with counter updates, and cell reads.
module ogrt_back #(
  parameter int GRID_DIM   = 256,
  parameter int COUNT_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  output logic           clearing,
  input  logic [7:0]     occ_threshold,
  input  logic           cmd_empty,
  input  ogrt_pkg::cmd_t cmd_data,
  output logic           cmd_pop,
  input  logic           res_full,
  output logic           res_push,
  output ogrt_pkg::res_t res_data
);

  import ogrt_pkg::*;

  localparam int DEPTH = GRID_DIM * GRID_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = AW + 8;
  localparam int CB    = COUNT_BITS;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_WALK  = 6'b000100,
    S_DRAIN = 6'b001000,
    S_READ1 = 6'b010000,
    S_READ2 = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  // Walker registers.
  logic [7:0]             x;
  logic [7:0]             y;
  logic signed [ERR_W-1:0] err;
  logic [7:0]             ex;
  logic [7:0]             ey;
  logic [7:0]             dx;
  logic [7:0]             dy_mag;
  logic                   x_neg;
  logic                   y_neg;
  logic [9:0]             walked;

  // Pending counter update of the cell read in the previous cycle.
  logic          pend_valid;
  logic          pend_free;
  logic          pend_hit;
  logic [AW-1:0] pend_addr;

  // Clearing pass and read pipeline.
  logic [AW-1:0]   clr_addr;
  logic [CB-1:0]   rd_hit;
  logic [CB-1:0]   rd_free;
  logic [CB+8:0]   rd_prod;
  logic            rd_zero;

  // RAM ports.
  logic          hit_we;
  logic          free_we;
  logic [AW-1:0] waddr;
  logic [CB-1:0] hit_wdata;
  logic [CB-1:0] free_wdata;
  logic [AW-1:0] raddr;
  logic [CB-1:0] hit_rdata;
  logic [CB-1:0] free_rdata;

  // Walk step terms.
  logic signed [ERR_W-1:0] dx_e;
  logic signed [ERR_W-1:0] dy_e;
  logic signed [ERR_W:0]   e2a;
  logic signed [ERR_W:0]   e2b;
  logic signed [ERR_W-1:0] err1;
  logic signed [ERR_W-1:0] err2;
  logic [7:0]              x1;
  logic [7:0]              y2;
  logic                    at_end;
  logic                    step_x;
  logic                    step_y;
  logic                    early_x;
  logic                    early_y;
  logic                    stop;

  // Read classification terms.
  logic [CB:0]   touches;
  logic [32:0]   hit_ext;
  logic [32:0]   free_ext;
  logic [CB+8:0] hit_scaled;

  function automatic logic [AW-1:0] cell_idx(input logic [7:0] cx, input logic [7:0] cy);
    logic [IW-1:0] p;
    p = IW'(cy) * IW'(GRID_DIM) + IW'(cx);
    return p[AW-1:0];
  endfunction

  assign clearing = (state == S_CLEAR);

  // One walker step: free count on the way, hit count at the stopping cell.
  assign dx_e    = $signed({{(ERR_W - 8){1'b0}}, dx});
  assign dy_e    = -$signed({{(ERR_W - 8){1'b0}}, dy_mag});
  assign at_end  = (x == ex) && (y == ey);
  assign e2a     = $signed({err, 1'b0});
  assign step_x  = !at_end && (e2a >= $signed({dy_e[ERR_W-1], dy_e}));
  assign early_x = step_x && (x == ex);
  assign err1    = (step_x && !early_x) ? err + dy_e : err;
  assign x1      = (step_x && !early_x) ? (x_neg ? x - 8'd1 : x + 8'd1) : x;
  assign e2b     = $signed({err1, 1'b0});
  assign step_y  = !at_end && !early_x && (e2b <= $signed({dx_e[ERR_W-1], dx_e}));
  assign early_y = step_y && (y == ey);
  assign err2    = (step_y && !early_y) ? err1 + dx_e : err1;
  assign y2      = (step_y && !early_y) ? (y_neg ? y - 8'd1 : y + 8'd1) : y;
  assign stop    = at_end || early_x || early_y;

  // Read address: the walker's cell while walking, else the queued request's cell.
  assign raddr = (state == S_WALK) ? cell_idx(x, y) : cell_idx(cmd_data.ax, cmd_data.ay);

  // Writes: zero fill during the clearing pass, else saturating increments.
  always_comb begin
    if (state == S_CLEAR) begin
      hit_we     = 1'b1;
      free_we    = 1'b1;
      waddr      = clr_addr;
      hit_wdata  = '0;
      free_wdata = '0;
    end else begin
      hit_we     = pend_valid && pend_hit;
      free_we    = pend_valid && pend_free;
      waddr      = pend_addr;
      hit_wdata  = (hit_rdata == '1) ? hit_rdata : hit_rdata + CB'(1);
      free_wdata = (free_rdata == '1) ? free_rdata : free_rdata + CB'(1);
    end
  end

  ogrt_ram #(.WIDTH(CB), .DEPTH(DEPTH)) u_hit_ram (
    .clk   (clk),
    .we    (hit_we),
    .waddr (waddr),
    .wdata (hit_wdata),
    .raddr (raddr),
    .rdata (hit_rdata)
  );

  ogrt_ram #(.WIDTH(CB), .DEPTH(DEPTH)) u_free_ram (
    .clk   (clk),
    .we    (free_we),
    .waddr (waddr),
    .wdata (free_wdata),
    .raddr (raddr),
    .rdata (free_rdata)
  );

  // Read classification operands.
  assign touches    = {1'b0, hit_rdata} + {1'b0, free_rdata};
  assign hit_scaled = {1'b0, rd_hit, 8'd0};
  assign hit_ext    = 33'(rd_hit);
  assign free_ext   = 33'(rd_free);

  // Sequencer.
  always_comb begin
    state_next = state;
    cmd_pop    = 1'b0;
    res_push   = 1'b0;
    res_data   = '0;
    case (state)
      S_CLEAR: begin
        if (clr_addr == AW'(DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!cmd_empty && !res_full) begin
          cmd_pop = 1'b1;
          case (cmd_data.op)
            OP_TRACE: state_next = S_WALK;
            OP_READ:  state_next = S_READ1;
            OP_REJECT: begin
              res_push          = 1'b1;
              res_data.rejected = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_WALK: begin
        if (stop) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        res_push              = 1'b1;
        res_data.cells_walked = walked;
        state_next            = S_IDLE;
      end
      S_READ1: begin
        state_next = S_READ2;
      end
      S_READ2: begin
        res_push   = 1'b1;
        state_next = S_IDLE;
        if (rd_zero) begin
          res_data.cell_class = CLASS_UNKNOWN;
        end else if (hit_scaled > rd_prod) begin
          res_data.cell_class = CLASS_OCCUPIED;
        end else begin
          res_data.cell_class = CLASS_FREE;
        end
        res_data.hit_total  = (hit_ext > REPORT_MAX) ? REPORT_MAX[15:0] : hit_ext[15:0];
        res_data.free_total = (free_ext > REPORT_MAX) ? REPORT_MAX[15:0] : free_ext[15:0];
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      pend_valid <= 1'b0;
      x          <= '0;
      y          <= '0;
      err        <= '0;
      walked     <= '0;
    end else begin
      state      <= state_next;
      pend_valid <= (state == S_WALK);
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (state == S_IDLE && cmd_pop && cmd_data.op == OP_TRACE) begin
        x      <= cmd_data.ax;
        y      <= cmd_data.ay;
        err    <= $signed({{(ERR_W - 8){1'b0}}, cmd_data.dx}) -
                  $signed({{(ERR_W - 8){1'b0}}, cmd_data.dy_mag});
        walked <= '0;
      end else if (state == S_WALK) begin
        x      <= x1;
        y      <= y2;
        err    <= err2;
        walked <= walked + 10'd1;
      end
    end
  end

  // Payload registers of the walk and the read pipeline.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && cmd_pop) begin
      ex     <= cmd_data.bx;
      ey     <= cmd_data.by;
      dx     <= cmd_data.dx;
      dy_mag <= cmd_data.dy_mag;
      x_neg  <= cmd_data.x_neg;
      y_neg  <= cmd_data.y_neg;
    end
    if (state == S_WALK) begin
      pend_addr <= cell_idx(x, y);
      pend_free <= !at_end;
      pend_hit  <= stop;
    end
    if (state == S_READ1) begin
      rd_hit  <= hit_rdata;
      rd_free <= free_rdata;
      rd_zero <= (hit_rdata == '0) && (free_rdata == '0);
      rd_prod <= (CB + 9)'(occ_threshold) * (CB + 9)'(touches);
    end
  end

endmodule

// ----- src/ogrt_checker.sv -----
// Port-level assertions for the occupancy grid ray tracer, bound to the top level.
`include "occupancy_grid_ray_tracer_top_macros.svh"

module ogrt_checker (
  input logic        clk,
  input logic        rst,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [1:0]  cell_class,
  input logic [15:0] hit_total,
  input logic [15:0] free_total,
  input logic [9:0]  cells_walked,
  input logic        rejected
);

  // Reset empties the result side and holds off requests for the clearing pass.
  `OGRT_ASSERT_AFTER_RESET(a_reset_state, full && empty, "reset did not block intake")

  // A result that is not taken stays in place.
  `OGRT_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(hit_total) && $stable(free_total) && $stable(cell_class), "stalled result changed")

  // A rejected request reports nothing else.
  `OGRT_ASSERT_NOW(a_reject_clean, !empty && rejected, cell_class == 2'd0 && hit_total == 16'd0 && free_total == 16'd0 && cells_walked == 10'd0, "rejected result carries data")

  // A trace result carries only its cell count, which stays within two grid sides.
  `OGRT_ASSERT_NOW(a_trace_clean, !empty && cells_walked != 10'd0, cell_class == 2'd0 && hit_total == 16'd0 && free_total == 16'd0 && !rejected && cells_walked <= 10'd512, "trace result malformed")

endmodule

bind occupancy_grid_ray_tracer_top ogrt_checker u_checker (.*);

// ----- test/occupancy_grid_ray_tracer_top_tb.sv -----
// Self-checking testbench for the occupancy grid ray tracer top level.
module occupancy_grid_ray_tracer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ogrt_pkg::*;

  localparam int CLK_PERIOD  = 20;
  localparam int GRID_DIM    = 256;
  localparam int GRID_CELLS  = GRID_DIM * GRID_DIM;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int MAX_SHOWN   = 10;
  localparam int TAIL_CYCLES = 600;

  // Index with no register behind it; writes to it must be ignored.
  localparam logic [1:0] REG_UNUSED = 2'd3;

  // One request as the sender presents it.
  typedef struct {
    logic       req_kind;
    logic [7:0] sx;
    logic [7:0] sy;
    logic [7:0] ex;
    logic [7:0] ey;
    logic [7:0] rx;
    logic [7:0] ry;
  } ray_req_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic        req_type = 1'b0;
  logic [7:0]  ray_start_x = '0;
  logic [7:0]  ray_start_y = '0;
  logic [7:0]  ray_end_x = '0;
  logic [7:0]  ray_end_y = '0;
  logic [7:0]  read_x = '0;
  logic [7:0]  read_y = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  cell_class;
  logic [15:0] hit_total;
  logic [15:0] free_total;
  logic [9:0]  cells_walked;
  logic        rejected;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [8:0]  cfg_data = '0;

  // Mirror of the block's counters and registers.
  logic [15:0] hit_count  [GRID_CELLS];
  logic [15:0] free_count [GRID_CELLS];
  logic [7:0]  occ_thr_cfg;
  logic [8:0]  width_cfg;
  logic [8:0]  height_cfg;

  res_t pending_results[$];

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int mismatch_count = 0;
  int results_seen = 0;
  int requests_sent = 0;
  int traces_sent = 0;
  int reads_sent = 0;
  int rejects_seen = 0;
  int cycle_count = 0;

  occupancy_grid_ray_tracer_top dut (.*);

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Saturating counter updates on the mirrored grid.
  function automatic void bump_hit(input int idx);
    if (hit_count[idx] != 16'hFFFF) hit_count[idx] = hit_count[idx] + 16'd1;
  endfunction

  function automatic void bump_free(input int idx);
    if (free_count[idx] != 16'hFFFF) free_count[idx] = free_count[idx] + 16'd1;
  endfunction

  function automatic int grid_in_use(input logic [8:0] reg_value);
    return (reg_value > GRID_DIM) ? GRID_DIM : int'(reg_value);
  endfunction

  // Walks the line cell by cell, marking free cells and the hit cell.
  function automatic logic [9:0] walk_ray(input int sx, input int sy, input int ex,
                                          input int ey);
    int dx, dy, stx, sty, err, x, y, walked, idx;
    dx = (ex > sx) ? ex - sx : sx - ex;
    dy = -((ey > sy) ? ey - sy : sy - ey);
    stx = (sx < ex) ? 1 : -1;
    sty = (sy < ey) ? 1 : -1;
    err = dx + dy;
    x = sx;
    y = sy;
    walked = 0;
    while (walked < 1023) begin
      idx = y * GRID_DIM + x;
      walked++;
      if (x == ex && y == ey) begin
        bump_hit(idx);
        break;
      end
      bump_free(idx);
      // An axis that is already done stops the walk on this cell.
      if (2 * err >= dy) begin
        if (x == ex) begin
          bump_hit(idx);
          break;
        end
        err += dy;
        x += stx;
      end
      if (2 * err <= dx) begin
        if (y == ey) begin
          bump_hit(idx);
          break;
        end
        err += dx;
        y += sty;
      end
    end
    return walked[9:0];
  endfunction

  // Computes the result of one accepted request and updates the mirror.
  function automatic res_t predict_result(input ray_req_t r);
    res_t out;
    int wu, hu, idx;
    logic [63:0] hv, fv, touches;
    out = '0;
    wu = grid_in_use(width_cfg);
    hu = grid_in_use(height_cfg);
    if (r.req_kind == REQ_READ) begin
      reads_sent++;
      if (r.rx >= wu || r.ry >= hu) begin
        out.rejected = 1'b1;
      end else begin
        idx = int'(r.ry) * GRID_DIM + int'(r.rx);
        hv = 64'(hit_count[idx]);
        fv = 64'(free_count[idx]);
        touches = hv + fv;
        if (touches == 0) out.cell_class = CLASS_UNKNOWN;
        else if (hv * 256 > 64'(occ_thr_cfg) * touches) out.cell_class = CLASS_OCCUPIED;
        else out.cell_class = CLASS_FREE;
        out.hit_total = hit_count[idx];
        out.free_total = free_count[idx];
      end
    end else begin
      traces_sent++;
      if (r.sx >= wu || r.ex >= wu || r.sy >= hu || r.ey >= hu) out.rejected = 1'b1;
      else out.cells_walked = walk_ray(int'(r.sx), int'(r.sy), int'(r.ex), int'(r.ey));
    end
    if (out.rejected) rejects_seen++;
    return out;
  endfunction

  // Presents one request, with optional idle cycles before it.
  task automatic send_request(input ray_req_t r);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    push <= 1'b1;
    req_type <= r.req_kind;
    ray_start_x <= r.sx;
    ray_start_y <= r.sy;
    ray_end_x <= r.ex;
    ray_end_y <= r.ey;
    read_x <= r.rx;
    read_y <= r.ry;
    do @(posedge clk); while (full);
    pending_results.push_back(predict_result(r));
    requests_sent++;
  endtask

  task automatic trace(input int sx, input int sy, input int ex, input int ey);
    ray_req_t r;
    r = '{REQ_TRACE, 8'(sx), 8'(sy), 8'(ex), 8'(ey),
          8'($urandom_range(255)), 8'($urandom_range(255))};
    send_request(r);
  endtask

  task automatic read_cell(input int x, input int y);
    ray_req_t r;
    r = '{REQ_READ, 8'($urandom_range(255)), 8'($urandom_range(255)),
          8'($urandom_range(255)), 8'($urandom_range(255)), 8'(x), 8'(y)};
    send_request(r);
  endtask

  // Register write; the mirror follows at the accepting edge.
  task automatic write_register(input logic [1:0] idx, input logic [8:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_OCC_THRESHOLD: occ_thr_cfg = value[7:0];
      REG_GRID_WIDTH:    width_cfg = value;
      REG_GRID_HEIGHT:   height_cfg = value;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Stops sending and waits for every pending result.
  task automatic wait_idle();
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic note_mismatch(input string what, input res_t want, input res_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_SHOWN)
      $display("%0t: %s: expected class=%0d hit=%0d free=%0d walked=%0d rej=%0d,",
               $realtime, what, want.cell_class, want.hit_total, want.free_total,
               want.cells_walked, want.rejected,
               " got class=%0d hit=%0d free=%0d walked=%0d rej=%0d",
               got.cell_class, got.hit_total, got.free_total, got.cells_walked,
               got.rejected);
  endtask

  // Result checker and receiver stall generator.
  always @(posedge clk) begin
    res_t got, want;
    if (!rst && pop && !empty) begin
      got = {cell_class, hit_total, free_total, cells_walked, rejected};
      results_seen++;
      if (pending_results.size() == 0) begin
        note_mismatch("result with no request pending", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) note_mismatch("result mismatch", want, got);
      end
    end
    pop <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
  end

  // Builds a random request for a grid of wu x hu cells.
  function automatic ray_req_t make_request(input int wu, input int hu);
    ray_req_t r;
    int pick;
    r = '{1'($urandom_range(1)), 8'($urandom_range(255)), 8'($urandom_range(255)),
          8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
          8'($urandom_range(255))};
    pick = $urandom_range(99);
    // Mostly in-range requests; a few raw ones and a few with one bad coordinate.
    if (pick >= 6) begin
      r.req_kind = ($urandom_range(99) < 45) ? REQ_READ : REQ_TRACE;
      r.sx = 8'($urandom_range(wu - 1));
      r.ex = 8'($urandom_range(wu - 1));
      r.rx = 8'($urandom_range(wu - 1));
      r.sy = 8'($urandom_range(hu - 1));
      r.ey = 8'($urandom_range(hu - 1));
      r.ry = 8'($urandom_range(hu - 1));
      if (pick < 12) begin
        case ($urandom_range(5))
          0: if (wu < GRID_DIM) r.sx = 8'($urandom_range(255, wu));
          1: if (wu < GRID_DIM) r.ex = 8'($urandom_range(255, wu));
          2: if (hu < GRID_DIM) r.sy = 8'($urandom_range(255, hu));
          3: if (hu < GRID_DIM) r.ey = 8'($urandom_range(255, hu));
          4: if (wu < GRID_DIM) r.rx = 8'($urandom_range(255, wu));
          default: if (hu < GRID_DIM) r.ry = 8'($urandom_range(255, hu));
        endcase
      end
    end
    return r;
  endfunction

  // Unknown cells after the clearing pass, then a one-cell ray.
  task automatic test_power_up();
    read_cell(0, 0);
    read_cell(255, 255);
    trace(0, 0, 0, 0);
    read_cell(0, 0);
  endtask

  // Horizontal, vertical, diagonal, steep and shallow rays in both directions.
  task automatic test_line_shapes();
    trace(0, 0, 255, 0);
    trace(255, 0, 255, 255);
    trace(255, 255, 0, 0);
    trace(10, 200, 13, 5);
    trace(200, 9, 3, 14);
    trace(128, 128, 127, 129);
    read_cell(1, 0);
    read_cell(255, 0);
    read_cell(100, 100);
    read_cell(12, 100);
    wait_idle();
  endtask

  // Threshold extremes, each followed by reads of cells that rays have touched.
  task automatic test_threshold();
    write_register(REG_OCC_THRESHOLD, 9'd0);
    read_cell(1, 0);
    read_cell(0, 0);
    wait_idle();
    write_register(REG_OCC_THRESHOLD, 9'd255);
    read_cell(255, 255);
    read_cell(0, 0);
    wait_idle();
  endtask

  // Bounds checks, an empty grid, oversized sizes and an unused index.
  task automatic test_grid_bounds();
    write_register(REG_GRID_WIDTH, 9'd10);
    write_register(REG_GRID_HEIGHT, 9'd7);
    trace(0, 0, 9, 6);
    trace(0, 0, 10, 0);
    trace(0, 7, 0, 0);
    read_cell(9, 6);
    read_cell(10, 0);
    read_cell(0, 7);
    wait_idle();
    write_register(REG_GRID_WIDTH, 9'd0);
    trace(0, 0, 0, 0);
    read_cell(0, 0);
    wait_idle();
    write_register(REG_GRID_WIDTH, 9'd511);
    write_register(REG_GRID_HEIGHT, 9'd300);
    write_register(REG_UNUSED, 9'd511);
    read_cell(255, 255);
    trace(255, 255, 0, 255);
    read_cell(0, 255);
    wait_idle();
  endtask

  task automatic run_phase(input int n, input int w, input int h, input int thr,
                           input int tx_pct, input int rx_pct);
    int wu, hu;
    wait_idle();
    write_register(REG_GRID_WIDTH, 9'(w));
    write_register(REG_GRID_HEIGHT, 9'(h));
    write_register(REG_OCC_THRESHOLD, 9'(thr));
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    wu = grid_in_use(width_cfg);
    hu = grid_in_use(height_cfg);
    repeat (n) send_request(make_request(wu, hu));
  endtask

  // Random traffic over several grid shapes, thresholds and idle patterns.
  task automatic test_random_traffic();
    run_phase(230, 16, 16, 128, 0, 0);
    run_phase(230, 32, 8, 0, 68, 0);
    run_phase(60, 1, 1, 255, 0, 68);
    run_phase(80, 511, 256, 200, 0, 68);
    run_phase(230, 12, 20, 77, 14, 14);
    run_phase(110, 256, 3, 1, 0, 0);
    run_phase(120, 7, 250, 254, 68, 0);
    run_phase(110, 2, 2, 64, 14, 14);
  endtask

  // Run limit.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d results pending", cycle_count,
             pending_results.size());
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    for (int i = 0; i < GRID_CELLS; i++) begin
      hit_count[i] = '0;
      free_count[i] = '0;
    end
    occ_thr_cfg = OCC_THRESHOLD_RESET;
    width_cfg = GRID_SIZE_RESET;
    height_cfg = GRID_SIZE_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_power_up();
    test_line_shapes();
    test_threshold();
    test_grid_bounds();
    test_random_traffic();

    // Drain, then watch a while for stray results.
    wait_idle();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d requests (%0d ray traces, %0d cell reads, %0d out of bounds).",
             requests_sent, traces_sent, reads_sent, rejects_seen);
    $display("Checked %0d results over %0d cycles, %0d mismatches.", results_seen,
             cycle_count, mismatch_count);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
